// ===== rtl/core/rdup_pkg.sv =====
package rdup_pkg;

  localparam int THR_W     = 20;
  localparam int RES_W     = 32;
  localparam int SCALE_SH  = 16;
  localparam int STAT_W    = 3;

  localparam logic [THR_W-1:0] DET_THR_RST = 20'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_MISS  = 3'd1,
    ST_XSING = 3'd2,
    ST_YSING = 3'd3,
    ST_BOTH  = 3'd4
  } status_t;

endpackage

// ===== rtl/core/rdup_dly.sv =====
module rdup_dly
  import rdup_pkg::*;
#(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) sh_r[i] <= '0;
    end else begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign q = sh_r[N-1];

endmodule

// ===== rtl/core/rdup_div.sv =====
module rdup_div
  import rdup_pkg::*;
#(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic          neg_i,
  output logic [QW-1:0] quo_o,
  output logic          neg_o
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          ovf_r [QW+1];
  logic          neg_r [QW+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(num_i);
    den_r[0] <= den_i;
    quo_r[0] <= '0;
    neg_r[0] <= neg_i;
    ovf_r[0] <= ({1'b0, RW'(num_i)} >= ({1'b0, RW'(den_i)} << QW));
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int SH = QW - 1 - g;
    logic [RW:0] trial;
    assign trial = {1'b0, rem_r[g]} - ({1'b0, RW'(den_r[g])} << SH);
    always_ff @(posedge clk) begin
      rem_r[g+1] <= trial[RW] ? rem_r[g] : trial[RW-1:0];
      quo_r[g+1] <= {quo_r[g][QW-2:0], ~trial[RW]};
      den_r[g+1] <= den_r[g];
      ovf_r[g+1] <= ovf_r[g];
      neg_r[g+1] <= neg_r[g];
    end
  end

  assign quo_o = ovf_r[QW] ? '1 : quo_r[QW];
  assign neg_o = neg_r[QW];

endmodule

// ===== rtl/core/ray_differential_uv_partials.sv =====
// Throughput: one request per cycle; busy is always low.
// Depth is set by the two bit-per-stage dividers (plane hit, then the 2x2 solve).
// The receiver cannot stall; each result is shown for one cycle on out_valid.
// Reset (synchronous, rst_n low) clears all valid bits and sets det_threshold to 1.
module ray_differential_uv_partials
  import rdup_pkg::*;
#(
  parameter int COMP_WIDTH = 21
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_has_diffs,
  input  logic [62:0]             in_hit_point,
  input  logic [62:0]             in_normal,
  input  logic [62:0]             in_tangent_u,
  input  logic [62:0]             in_tangent_v,
  input  logic [62:0]             in_offset_x_origin,
  input  logic [62:0]             in_offset_x_dir,
  input  logic [62:0]             in_offset_y_origin,
  input  logic [62:0]             in_offset_y_dir,
  input  logic                    cfg_we,
  input  logic [THR_W-1:0]        cfg_wdata,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] out_du_dx,
  output logic signed [RES_W-1:0] out_dv_dx,
  output logic signed [RES_W-1:0] out_du_dy,
  output logic signed [RES_W-1:0] out_dv_dy,
  output logic [62:0]             out_pos_dx,
  output logic [62:0]             out_pos_dy,
  output logic [STAT_W-1:0]       out_status
);

  localparam int CW    = COMP_WIDTH;
  localparam int PW    = 2 * CW;
  localparam int DOTW  = PW + 2;
  localparam int NUMW  = DOTW + 1;
  localparam int NGW   = NUMW + 1;
  localparam int MW    = NGW + CW;
  localparam int DIFW  = CW + 1;
  localparam int Q1    = CW + 2;
  localparam int SW    = CW + 4;
  localparam int DTW   = PW + 1;
  localparam int NW2   = DTW + SCALE_SH;
  localparam int SB1W  = 2 + 4 + 4 * CW + 6 * DIFW;
  localparam int SB2W  = 3 + 6 * CW;

  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= DET_THR_RST;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // unpack
  logic signed [CW-1:0] p_c [3];
  logic signed [CW-1:0] n_c [3];
  logic signed [CW-1:0] tu_c [3];
  logic signed [CW-1:0] tv_c [3];
  logic signed [CW-1:0] o_c [2][3];
  logic signed [CW-1:0] d_c [2][3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_unp
    assign p_c[gi]    = in_hit_point[gi*CW +: CW];
    assign n_c[gi]    = in_normal[gi*CW +: CW];
    assign tu_c[gi]   = in_tangent_u[gi*CW +: CW];
    assign tv_c[gi]   = in_tangent_v[gi*CW +: CW];
    assign o_c[0][gi] = in_offset_x_origin[gi*CW +: CW];
    assign d_c[0][gi] = in_offset_x_dir[gi*CW +: CW];
    assign o_c[1][gi] = in_offset_y_origin[gi*CW +: CW];
    assign d_c[1][gi] = in_offset_y_dir[gi*CW +: CW];
  end

  logic [CW-1:0] an [3];
  logic [1:0]    a0, a1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an[i] = n_c[i][CW-1] ? CW'(-n_c[i]) : CW'(n_c[i]);
    end
    if (an[0] > an[1] && an[0] > an[2]) begin
      a0 = 2'd1;
      a1 = 2'd2;
    end else if (an[1] > an[2]) begin
      a0 = 2'd0;
      a1 = 2'd2;
    end else begin
      a0 = 2'd0;
      a1 = 2'd1;
    end
  end

  // stage 1: dot product terms
  logic signed [PW-1:0]   np1_r [3];
  logic signed [PW-1:0]   no1_r [2][3];
  logic signed [PW-1:0]   nd1_r [2][3];
  logic signed [DIFW-1:0] df1_r [2][3];
  logic signed [CW-1:0]   dr1_r [2][3];
  logic signed [CW-1:0]   tg1_r [4];
  logic [3:0]             ax1_r;
  logic                   hd1_r, v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      np1_r[i] <= n_c[i] * p_c[i];
      for (int k = 0; k < 2; k++) begin
        no1_r[k][i] <= n_c[i] * o_c[k][i];
        nd1_r[k][i] <= n_c[i] * d_c[k][i];
        df1_r[k][i] <= DIFW'(o_c[k][i]) - DIFW'(p_c[i]);
        dr1_r[k][i] <= d_c[k][i];
      end
    end
    tg1_r[0] <= tu_c[a0];
    tg1_r[1] <= tv_c[a0];
    tg1_r[2] <= tu_c[a1];
    tg1_r[3] <= tv_c[a1];
    ax1_r    <= {a1, a0};
    hd1_r    <= in_has_diffs;
  end

  // stage 2: plane numerator and denominator
  logic signed [NUMW-1:0] num2_r [2];
  logic signed [DOTW-1:0] den2_r [2];
  logic signed [DIFW-1:0] df2_r [2][3];
  logic signed [CW-1:0]   dr2_r [2][3];
  logic signed [CW-1:0]   tg2_r [4];
  logic [3:0]             ax2_r;
  logic                   hd2_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      num2_r[k] <= (NUMW'(no1_r[k][0]) + NUMW'(no1_r[k][1]) + NUMW'(no1_r[k][2]))
                 - (NUMW'(np1_r[0]) + NUMW'(np1_r[1]) + NUMW'(np1_r[2]));
      den2_r[k] <= DOTW'(nd1_r[k][0]) + DOTW'(nd1_r[k][1]) + DOTW'(nd1_r[k][2]);
    end
    df2_r <= df1_r;
    dr2_r <= dr1_r;
    tg2_r <= tg1_r;
    ax2_r <= ax1_r;
    hd2_r <= hd1_r;
  end

  // stage 3: scaled numerators
  logic signed [MW-1:0]   prd3_r [2][3];
  logic signed [DOTW-1:0] den3_r [2];
  logic signed [DIFW-1:0] df3_r [2][3];
  logic signed [CW-1:0]   tg3_r [4];
  logic [3:0]             ax3_r;
  logic                   ok3_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        prd3_r[k][i] <= (-NGW'(num2_r[k])) * dr2_r[k][i];
      end
    end
    den3_r <= den2_r;
    ok3_r  <= hd2_r && (den2_r[0] != '0) && (den2_r[1] != '0);
    df3_r  <= df2_r;
    tg3_r  <= tg2_r;
    ax3_r  <= ax2_r;
  end

  // plane intersection dividers
  logic [Q1-1:0] q4 [2][3];
  logic          qn4 [2][3];

  for (genvar gk = 0; gk < 2; gk++) begin : g_pk
    logic [DOTW-1:0] dmag;
    assign dmag = den3_r[gk][DOTW-1] ? DOTW'(-den3_r[gk]) : DOTW'(den3_r[gk]);
    for (genvar gi = 0; gi < 3; gi++) begin : g_pi
      logic [MW-1:0] nmag;
      assign nmag = prd3_r[gk][gi][MW-1] ? MW'(-prd3_r[gk][gi]) : MW'(prd3_r[gk][gi]);
      rdup_div #(.NW(MW), .DW(DOTW), .QW(Q1)) u_div (
        .clk   (clk),
        .num_i (nmag),
        .den_i (dmag),
        .neg_i (prd3_r[gk][gi][MW-1] ^ den3_r[gk][DOTW-1]),
        .quo_o (q4[gk][gi]),
        .neg_o (qn4[gk][gi])
      );
    end
  end

  logic [SB1W-1:0]        sb1_d, sb1_q;
  logic signed [DIFW-1:0] df4 [2][3];
  logic signed [CW-1:0]   tg4 [4];
  logic [3:0]             ax4;
  logic                   ok4, v4;

  for (genvar gk = 0; gk < 2; gk++) begin : g_s1k
    for (genvar gi = 0; gi < 3; gi++) begin : g_s1i
      assign sb1_d[(gk*3+gi)*DIFW +: DIFW] = df3_r[gk][gi];
      assign df4[gk][gi] = sb1_q[(gk*3+gi)*DIFW +: DIFW];
    end
  end
  for (genvar gt = 0; gt < 4; gt++) begin : g_s1t
    assign sb1_d[6*DIFW + gt*CW +: CW] = tg3_r[gt];
    assign tg4[gt] = sb1_q[6*DIFW + gt*CW +: CW];
  end
  assign sb1_d[SB1W-1 -: 6] = {v3_r, ok3_r, ax3_r};
  assign {v4, ok4, ax4}     = sb1_q[SB1W-1 -: 6];

  rdup_dly #(.W(SB1W), .N(Q1 + 1)) u_dly1 (
    .clk   (clk),
    .rst_n (rst_n),
    .d     (sb1_d),
    .q     (sb1_q)
  );

  // stage 5: position differentials
  logic signed [CW-1:0] pd5_r [2][3];
  logic signed [CW-1:0] tg5_r [4];
  logic [3:0]           ax5_r;
  logic                 ok5_r, v5_r;
  logic signed [CW-1:0] pd5_nxt [2][3];

  always_comb begin
    logic signed [Q1:0]   qs;
    logic signed [SW-1:0] sm;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        qs = qn4[k][i] ? -$signed({1'b0, q4[k][i]}) : $signed({1'b0, q4[k][i]});
        sm = SW'(df4[k][i]) + SW'(qs);
        if (sm > $signed(SW'({1'b0, {(CW-1){1'b1}}}))) begin
          pd5_nxt[k][i] = {1'b0, {(CW-1){1'b1}}};
        end else if (sm < -$signed(SW'({1'b0, {(CW-1){1'b1}}})) - $signed(SW'(1))) begin
          pd5_nxt[k][i] = {1'b1, {(CW-1){1'b0}}};
        end else begin
          pd5_nxt[k][i] = CW'(sm);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4;
  end

  always_ff @(posedge clk) begin
    pd5_r <= pd5_nxt;
    tg5_r <= tg4;
    ax5_r <= ax4;
    ok5_r <= ok4;
  end

  // stage 6: solver products
  logic signed [PW-1:0] pa6_r [2];
  logic signed [PW-1:0] pb6_r [2];
  logic signed [PW-1:0] pc6_r [2];
  logic signed [PW-1:0] pd6p_r [2];
  logic signed [PW-1:0] pe6_r, pf6_r;
  logic signed [CW-1:0] pd6_r [2][3];
  logic                 ok6_r, v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      pa6_r[k]  <= tg5_r[3] * pd5_r[k][ax5_r[1:0]];
      pb6_r[k]  <= tg5_r[1] * pd5_r[k][ax5_r[3:2]];
      pc6_r[k]  <= tg5_r[0] * pd5_r[k][ax5_r[3:2]];
      pd6p_r[k] <= tg5_r[2] * pd5_r[k][ax5_r[1:0]];
    end
    pe6_r <= tg5_r[0] * tg5_r[3];
    pf6_r <= tg5_r[1] * tg5_r[2];
    pd6_r <= pd5_r;
    ok6_r <= ok5_r;
  end

  // stage 7: cofactors and determinant
  logic signed [DTW-1:0] nn7_r [4];
  logic signed [DTW-1:0] det7_r;
  logic                  sg7_r;
  logic signed [CW-1:0]  pd7_r [2][3];
  logic                  ok7_r, v7_r;
  logic signed [DTW-1:0] det_nxt;
  logic [DTW-1:0]        detm_nxt;

  assign det_nxt  = DTW'(pe6_r) - DTW'(pf6_r);
  assign detm_nxt = det_nxt[DTW-1] ? DTW'(-det_nxt) : DTW'(det_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      nn7_r[2*k]   <= DTW'(pa6_r[k]) - DTW'(pb6_r[k]);
      nn7_r[2*k+1] <= DTW'(pc6_r[k]) - DTW'(pd6p_r[k]);
    end
    det7_r <= det_nxt;
    sg7_r  <= (det_nxt == '0) || (detm_nxt < DTW'(thr_r));
    pd7_r  <= pd6_r;
    ok7_r  <= ok6_r;
  end

  // solve dividers
  logic [RES_W-1:0] q8 [4];
  logic             qn8 [4];
  logic [DTW-1:0]   detm7;

  assign detm7 = det7_r[DTW-1] ? DTW'(-det7_r) : DTW'(det7_r);

  for (genvar gj = 0; gj < 4; gj++) begin : g_sol
    logic [DTW-1:0] nm;
    assign nm = nn7_r[gj][DTW-1] ? DTW'(-nn7_r[gj]) : DTW'(nn7_r[gj]);
    rdup_div #(.NW(NW2), .DW(DTW), .QW(RES_W)) u_div (
      .clk   (clk),
      .num_i ({nm, {SCALE_SH{1'b0}}}),
      .den_i (detm7),
      .neg_i (nn7_r[gj][DTW-1] ^ det7_r[DTW-1]),
      .quo_o (q8[gj]),
      .neg_o (qn8[gj])
    );
  end

  logic [SB2W-1:0] sb2_d, sb2_q;
  logic            v8, ok8, sg8;

  for (genvar gk = 0; gk < 2; gk++) begin : g_s2k
    for (genvar gi = 0; gi < 3; gi++) begin : g_s2i
      assign sb2_d[(gk*3+gi)*CW +: CW] = pd7_r[gk][gi];
    end
  end
  assign sb2_d[SB2W-1 -: 3] = {v7_r, ok7_r, sg7_r};
  assign {v8, ok8, sg8}     = sb2_q[SB2W-1 -: 3];

  rdup_dly #(.W(SB2W), .N(RES_W + 1)) u_dly2 (
    .clk   (clk),
    .rst_n (rst_n),
    .d     (sb2_d),
    .q     (sb2_q)
  );

  // output register
  logic [RES_W-1:0] r8 [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (qn8[j]) begin
        r8[j] = q8[j] >= {1'b1, {(RES_W-1){1'b0}}} ? {1'b1, {(RES_W-1){1'b0}}} : -q8[j];
      end else begin
        r8[j] = q8[j][RES_W-1] ? {1'b0, {(RES_W-1){1'b1}}} : q8[j];
      end
    end
  end

  logic                    out_valid_r;
  logic [RES_W-1:0]        res_r [4];
  logic [62:0]             pdx_r, pdy_r;
  status_t                 st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v8;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      res_r[j] <= (ok8 && !sg8) ? r8[j] : '0;
    end
    pdx_r <= ok8 ? 63'(sb2_q[3*CW-1:0])    : '0;
    pdy_r <= ok8 ? 63'(sb2_q[6*CW-1:3*CW]) : '0;
    if (!ok8)     st_r <= ST_MISS;
    else if (sg8) st_r <= ST_BOTH;
    else          st_r <= ST_OK;
  end

  assign out_valid  = out_valid_r;
  assign out_du_dx  = res_r[0];
  assign out_dv_dx  = res_r[1];
  assign out_du_dy  = res_r[2];
  assign out_dv_dy  = res_r[3];
  assign out_pos_dx = pdx_r;
  assign out_pos_dy = pdy_r;
  assign out_status = st_r;

endmodule

// ===== sim/ray_differential_uv_partials_chk.sv =====
module ray_differential_uv_partials_chk
  import rdup_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_has_diffs,
  input  logic [62:0]             in_hit_point,
  input  logic [62:0]             in_normal,
  input  logic [62:0]             in_tangent_u,
  input  logic [62:0]             in_tangent_v,
  input  logic [62:0]             in_offset_x_origin,
  input  logic [62:0]             in_offset_x_dir,
  input  logic [62:0]             in_offset_y_origin,
  input  logic [62:0]             in_offset_y_dir,
  input  logic                    cfg_we,
  input  logic [THR_W-1:0]        cfg_wdata,
  input  logic                    out_valid,
  input  logic signed [RES_W-1:0] out_du_dx,
  input  logic signed [RES_W-1:0] out_dv_dx,
  input  logic signed [RES_W-1:0] out_du_dy,
  input  logic signed [RES_W-1:0] out_dv_dy,
  input  logic [62:0]             out_pos_dx,
  input  logic [62:0]             out_pos_dy,
  input  logic [STAT_W-1:0]       out_status,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 21;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [RES_W-1:0] du_dx;
    logic [RES_W-1:0] dv_dx;
    logic [RES_W-1:0] du_dy;
    logic [RES_W-1:0] dv_dy;
    logic [62:0]      pos_dx;
    logic [62:0]      pos_dy;
    status_t          status;
  } uv_partials_t;

  uv_partials_t partials_q[$];
  logic [THR_W-1:0] det_thr;

  function automatic wide_t comp(logic [62:0] w, int i);
    return wide_t'(signed'(w[i*CW +: CW]));
  endfunction

  function automatic wide_t clamp(wide_t v, int bits);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic wide_t dot3(logic [62:0] a, logic [62:0] b);
    return comp(a, 0) * comp(b, 0) + comp(a, 1) * comp(b, 1) + comp(a, 2) * comp(b, 2);
  endfunction

  function automatic wide_t mag(wide_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic solve_uv(wide_t u0, wide_t v0, wide_t u1, wide_t v1,
                                    wide_t b0, wide_t b1,
                                    output logic [RES_W-1:0] du,
                                    output logic [RES_W-1:0] dv);
    wide_t det;
    det = u0 * v1 - v0 * u1;
    du = '0;
    dv = '0;
    if (det == 0 || mag(det) < wide_t'(det_thr)) return 1'b0;
    du = RES_W'(clamp(((v1 * b0 - v0 * b1) * 65536) / det, 32));
    dv = RES_W'(clamp(((u0 * b1 - u1 * b0) * 65536) / det, 32));
    return 1'b1;
  endfunction

  function automatic uv_partials_t predict_partials();
    uv_partials_t r;
    logic [62:0] org[2], dir[2], pd[2];
    wide_t dp, num, den, q, an0, an1, an2;
    logic ok, sx, sy;
    int a0, a1;
    r = '{status: ST_OK, default: '0};
    org[0] = in_offset_x_origin;
    dir[0] = in_offset_x_dir;
    org[1] = in_offset_y_origin;
    dir[1] = in_offset_y_dir;
    ok = in_has_diffs;
    dp = dot3(in_normal, in_hit_point);
    for (int k = 0; k < 2; k++) begin
      num = dot3(in_normal, org[k]) - dp;
      den = dot3(in_normal, dir[k]);
      pd[k] = '0;
      if (den == 0) ok = 1'b0;
      if (ok) begin
        for (int i = 0; i < 3; i++) begin
          q = (-num * comp(dir[k], i)) / den;
          pd[k][i*CW +: CW] = CW'(clamp(comp(org[k], i) - comp(in_hit_point, i)
                                        + clamp(q, 40), CW));
        end
      end
    end
    if (!ok) begin
      r.status = ST_MISS;
      return r;
    end
    an0 = mag(comp(in_normal, 0));
    an1 = mag(comp(in_normal, 1));
    an2 = mag(comp(in_normal, 2));
    if (an0 > an1 && an0 > an2) begin
      a0 = 1; a1 = 2;
    end else if (an1 > an2) begin
      a0 = 0; a1 = 2;
    end else begin
      a0 = 0; a1 = 1;
    end
    sx = solve_uv(comp(in_tangent_u, a0), comp(in_tangent_v, a0),
                  comp(in_tangent_u, a1), comp(in_tangent_v, a1),
                  comp(pd[0], a0), comp(pd[0], a1), r.du_dx, r.dv_dx);
    sy = solve_uv(comp(in_tangent_u, a0), comp(in_tangent_v, a0),
                  comp(in_tangent_u, a1), comp(in_tangent_v, a1),
                  comp(pd[1], a0), comp(pd[1], a1), r.du_dy, r.dv_dy);
    r.pos_dx = pd[0];
    r.pos_dy = pd[1];
    if (!sx && !sy) r.status = ST_BOTH;
    else if (!sx) r.status = ST_XSING;
    else if (!sy) r.status = ST_YSING;
    else r.status = ST_OK;
    return r;
  endfunction

  task automatic report(string field, logic [62:0] got, logic [62:0] want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %h want %h at %0t", field, got, want, $time);
  endtask

  assign pending = partials_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    uv_partials_t e;
    if (!rst_n) begin
      det_thr <= DET_THR_RST;
      partials_q.delete();
    end else begin
      if (out_valid) begin
        if (partials_q.size() == 0) begin
          report("unexpected result", 63'(out_status), '0);
        end else begin
          e = partials_q.pop_front();
          if (out_du_dx !== e.du_dx) report("du_dx", 63'(out_du_dx), 63'(e.du_dx));
          if (out_dv_dx !== e.dv_dx) report("dv_dx", 63'(out_dv_dx), 63'(e.dv_dx));
          if (out_du_dy !== e.du_dy) report("du_dy", 63'(out_du_dy), 63'(e.du_dy));
          if (out_dv_dy !== e.dv_dy) report("dv_dy", 63'(out_dv_dy), 63'(e.dv_dy));
          if (out_pos_dx !== e.pos_dx) report("pos_dx", out_pos_dx, e.pos_dx);
          if (out_pos_dy !== e.pos_dy) report("pos_dy", out_pos_dy, e.pos_dy);
          if (out_status !== e.status) report("status", 63'(out_status), 63'(e.status));
        end
      end
      if (start && !busy) partials_q.push_back(predict_partials());
      if (cfg_we) det_thr <= cfg_wdata;
    end
  end
endmodule

// ===== sim/ray_differential_uv_partials_tb.sv =====
module ray_differential_uv_partials_tb;
  import rdup_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 64;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_has_diffs = 1'b0;
  logic [62:0]             in_hit_point = '0;
  logic [62:0]             in_normal = '0;
  logic [62:0]             in_tangent_u = '0;
  logic [62:0]             in_tangent_v = '0;
  logic [62:0]             in_offset_x_origin = '0;
  logic [62:0]             in_offset_x_dir = '0;
  logic [62:0]             in_offset_y_origin = '0;
  logic [62:0]             in_offset_y_dir = '0;
  logic                    cfg_we = 1'b0;
  logic [THR_W-1:0]        cfg_wdata = '0;
  logic                    out_valid;
  logic signed [RES_W-1:0] out_du_dx, out_dv_dx, out_du_dy, out_dv_dy;
  logic [62:0]             out_pos_dx, out_pos_dy;
  logic [STAT_W-1:0]       out_status;
  int                      errors, pending;

  always #4 clk = ~clk;

  ray_differential_uv_partials u_dut (.*);

  ray_differential_uv_partials_chk u_chk (.*);

  function automatic logic [62:0] vec3(int x, int y, int z);
    logic [20:0] a, b, c;
    a = x[20:0];
    b = y[20:0];
    c = z[20:0];
    return {c, b, a};
  endfunction

  function automatic int rand_comp(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic [62:0] rand_vec(int span);
    if (span >= (1 << 20)) return 63'({$urandom, $urandom});
    return vec3(rand_comp(span), rand_comp(span), rand_comp(span));
  endfunction

  task automatic send_req(logic hd, logic [62:0] p, logic [62:0] n, logic [62:0] tu,
                          logic [62:0] tv, logic [62:0] xo, logic [62:0] xd,
                          logic [62:0] yo, logic [62:0] yd);
    start <= 1'b1;
    in_has_diffs <= hd;
    in_hit_point <= p;
    in_normal <= n;
    in_tangent_u <= tu;
    in_tangent_v <= tv;
    in_offset_x_origin <= xo;
    in_offset_x_dir <= xd;
    in_offset_y_origin <= yo;
    in_offset_y_dir <= yd;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_random_req();
    int span, sel;
    logic [62:0] n, tu, tv, xd, yd;
    sel = $urandom_range(99);
    span = sel < 30 ? 64 : sel < 75 ? 2048 : sel < 90 ? 65536 : (1 << 20);
    n = rand_vec(span);
    tu = rand_vec(span);
    tv = rand_vec(span);
    xd = rand_vec(span);
    yd = rand_vec(span);
    if ($urandom_range(19) == 0) tv = tu;
    if ($urandom_range(19) == 0) xd = '0;
    if ($urandom_range(29) == 0) yd = '0;
    send_req($urandom_range(15) != 0, rand_vec(span), n, tu, tv,
             rand_vec(span), xd, rand_vec(span), yd);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic run_phase(int count, int idle_pct);
    for (int i = 0; i < count; i++) begin
      while (int'($urandom_range(99)) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk);
      end
      send_random_req();
    end
  endtask

  initial begin
    logic [62:0] ones;
    ones = '1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_req(1'b0, rand_vec(2048), vec3(0, 0, 1024), vec3(1024, 0, 0), vec3(0, 1024, 0),
             vec3(0, 0, 1024), vec3(0, 0, -1024), vec3(0, 0, 1024), vec3(0, 0, -1024));
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(1024, 0, 0), vec3(0, 1024, 0),
             vec3(10, 0, 1024), vec3(0, 0, -1024), vec3(0, 10, 1024), vec3(0, 0, -1024));
    send_req(1'b1, '0, vec3(1024, 0, 0), vec3(0, 1024, 0), vec3(0, 0, 1024),
             vec3(1024, 5, 0), vec3(-1024, 0, 0), vec3(1024, 0, 7), vec3(-1024, 0, 0));
    send_req(1'b1, '0, vec3(0, 1024, 0), vec3(1024, 0, 0), vec3(0, 0, 1024),
             vec3(3, 1024, 0), vec3(0, -1024, 0), vec3(0, 1024, 9), vec3(0, -512, 0));
    send_req(1'b1, '0, vec3(500, 500, 500), vec3(1024, 0, 0), vec3(0, 1024, 0),
             vec3(100, 0, 0), vec3(0, 0, -1024), vec3(0, 100, 0), vec3(0, 0, -1024));
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(1024, 0, 0), vec3(0, 1024, 0),
             vec3(0, 0, 1024), vec3(1024, 0, 0), vec3(0, 0, 1024), vec3(0, 0, -1024));
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(1024, 0, 0), vec3(0, 1024, 0),
             vec3(0, 0, 1024), vec3(0, 0, -1024), vec3(0, 0, 1024), vec3(0, 1024, 0));
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(1024, 512, 0), vec3(2048, 1024, 0),
             vec3(5, 5, 1024), vec3(0, 0, -1024), vec3(5, 9, 1024), vec3(0, 0, -1024));
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(1, 0, 0), vec3(0, 1, 0),
             vec3(1000000, -1000000, 1024), vec3(0, 0, -1), vec3(-1048576, 1048575, 1024),
             vec3(0, 0, -1));
    send_req(1'b1, vec3(1048575, -1048576, 0), vec3(-1048576, 1048575, 1),
             vec3(1048575, 1, 0), vec3(-1048576, 0, 1), vec3(-1048576, 1048575, 0),
             vec3(1, 1, 1), vec3(1048575, -1048576, 1048575), vec3(-1048576, 0, 3));
    send_req(1'b1, ones, ones, ones, ones, ones, ones, ones, ones);
    send_req(1'b1, '0, '0, '0, '0, '0, '0, '0, '0);
    send_req(1'b1, ones, vec3(0, 0, 1024), vec3(1024, 0, 0), vec3(0, 1024, 0), '0,
             vec3(0, 0, 1024), ones, vec3(7, 7, 1024));
    drain();
    write_threshold('0);
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(1024, 512, 0), vec3(2048, 1024, 0),
             vec3(5, 5, 1024), vec3(0, 0, -1024), vec3(5, 9, 1024), vec3(0, 0, -1024));
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(3, 0, 0), vec3(0, 3, 0),
             vec3(5, 5, 1024), vec3(0, 0, -1024), vec3(5, 9, 1024), vec3(0, 0, -1024));
    run_phase(530, 37);
    drain();
    write_threshold(20'hFFFFF);
    send_req(1'b1, '0, vec3(0, 0, 1024), vec3(1024, 0, 0), vec3(0, 1023, 0),
             vec3(100, 50, 1024), vec3(0, 0, -1024), vec3(9, 9, 1024), vec3(0, 0, -1024));
    run_phase(540, 69);
    drain();
    write_threshold(20'($urandom_range(20'hFFFFF)));
    run_phase(300, 0);
    drain();
    write_threshold(20'd1);
    run_phase(250, 0);
    drain();
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/rdup_pkg.sv
rtl/core/rdup_dly.sv
rtl/core/rdup_div.sv
rtl/core/ray_differential_uv_partials.sv
sim/ray_differential_uv_partials_chk.sv
sim/ray_differential_uv_partials_tb.sv
